[rtl/jlcg_pkg.sv]
// Package for the 48-bit LCG random generator.
// Holds the command codes, controller states, handshake structs and LCG constants.
package jlcg_pkg;

	localparam int SEED_W   = 48;
	localparam int VALUE_W  = 64;
	localparam int BOUND_W  = 31;
	localparam int SVAL_W   = 64;
	localparam int CMD_W    = 3;
	localparam int CHUNK_W  = 16;
	localparam int MULT_W   = 35;
	localparam int DIVCNT_W = 5;
	localparam int S_DATA_W = 104;

	localparam logic [MULT_W-1:0]   LCG_MULT = 35'h5DEECE66D;
	localparam logic [SEED_W-1:0]   LCG_ADD  = 48'd11;
	localparam logic [DIVCNT_W-1:0] DIV_LAST = 5'd30;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESEED  = 3'd0,
		CMD_INT     = 3'd1,
		CMD_BOUNDED = 3'd2,
		CMD_LONG    = 3'd3,
		CMD_DOUBLE  = 3'd4,
		CMD_BOOL    = 3'd5,
		CMD_FLOAT   = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_HI,
		ST_DLOAD,
		ST_DIV,
		ST_CHECK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic reseed;
		logic mul_step;
		logic hold_hi;
		logic div_start;
		logic div_step;
		logic write_out;
		cmd_t op;
	} jlcg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mul_last;
		logic div_last;
		logic pow2;
		logic reject;
		logic out_free;
	} jlcg_stat_t;

endpackage

[rtl/jlcg_dp.sv]
// Datapath: seed register, 3-pass LCG multiplier, serial remainder unit, output register.
// Depends on jlcg_pkg.
module jlcg_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [jlcg_pkg::SVAL_W-1:0]     seed_value,
	input  logic [jlcg_pkg::BOUND_W-1:0]    bound,
	input  jlcg_pkg::jlcg_cmd_t             cmd,
	output jlcg_pkg::jlcg_stat_t            status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [jlcg_pkg::VALUE_W-1:0]    m_tdata
);
	import jlcg_pkg::*;

	logic [SEED_W-1:0]    seed_q;
	logic [SEED_W-1:0]    acc_q;
	logic [1:0]           phase_q;
	logic [BOUND_W-1:0]   bound_q;
	logic [31:0]          hi_q;
	logic [BOUND_W-1:0]   r_q;
	logic [BOUND_W-1:0]   div_sh_q;
	logic [BOUND_W-1:0]   rem_q;
	logic [DIVCNT_W-1:0]  div_cnt_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 out_valid_q;

	logic [CHUNK_W-1:0]          chunk;
	logic [CHUNK_W+MULT_W-1:0]   pprod;
	logic [SEED_W-1:0]           pprod_sh;
	logic [SEED_W-1:0]           acc_next;
	logic [BOUND_W-1:0]          draw31;
	logic [2*BOUND_W-1:0]        bprod;
	logic [BOUND_W:0]            trial;
	logic [BOUND_W:0]            trial_sub;
	logic [BOUND_W-1:0]          rem_next;
	logic [31:0]                 chk;
	logic [VALUE_W-1:0]          result;

	// partial product of one 16-bit seed chunk with the multiplier
	always_comb begin
		case (phase_q)
			2'd0: chunk = seed_q[15:0];
			2'd1: chunk = seed_q[31:16];
			default: chunk = seed_q[47:32];
		endcase
		pprod = {{MULT_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, LCG_MULT};
		case (phase_q)
			2'd0: pprod_sh = pprod[SEED_W-1:0];
			2'd1: pprod_sh = {pprod[SEED_W-17:0], 16'd0};
			default: pprod_sh = {pprod[SEED_W-33:0], 32'd0};
		endcase
		acc_next = ((phase_q == 2'd0) ? LCG_ADD : acc_q) + pprod_sh;
	end

	assign status.mul_last = (phase_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			phase_q <= 2'd0;
		end else begin
			if (cmd.reseed) begin
				seed_q <= seed_value[SEED_W-1:0] ^ {{(SEED_W-MULT_W){1'b0}}, LCG_MULT};
			end else if (cmd.mul_step && status.mul_last) begin
				seed_q <= acc_next;
			end
			if (cmd.mul_step) begin
				phase_q <= status.mul_last ? 2'd0 : phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			acc_q <= acc_next;
		end
		if (cmd.load) begin
			bound_q <= bound;
		end
		if (cmd.hold_hi) begin
			hi_q <= (cmd.op == CMD_DOUBLE) ? {6'd0, seed_q[47:22]} : seed_q[47:16];
		end
	end

	// bounded draw helpers
	assign draw31      = seed_q[47:17];
	assign status.pow2 = ((bound_q & (~bound_q + 1'b1)) == bound_q);
	assign bprod       = {{BOUND_W{1'b0}}, bound_q} * {{BOUND_W{1'b0}}, draw31};

	// restoring remainder, one dividend bit a cycle
	always_comb begin
		trial     = {rem_q, div_sh_q[BOUND_W-1]};
		trial_sub = trial - {1'b0, bound_q};
		rem_next  = (trial >= {1'b0, bound_q}) ? trial_sub[BOUND_W-1:0] : trial[BOUND_W-1:0];
		chk       = {1'b0, r_q} - {1'b0, rem_q} + {1'b0, bound_q} - 32'd1;
	end

	assign status.div_last = (div_cnt_q == DIV_LAST);
	assign status.reject   = chk[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			r_q      <= draw31;
			div_sh_q <= draw31;
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			div_sh_q <= {div_sh_q[BOUND_W-2:0], 1'b0};
			rem_q    <= rem_next;
		end
	end

	// result select
	always_comb begin
		case (cmd.op)
			CMD_INT:     result = {{32{seed_q[47]}}, seed_q[47:16]};
			CMD_BOUNDED: result = status.pow2 ? {33'd0, bprod[2*BOUND_W-1:BOUND_W]}
			                                  : {33'd0, rem_q};
			CMD_LONG:    result = {hi_q, 32'd0} + {{32{seed_q[47]}}, seed_q[47:16]};
			CMD_DOUBLE:  result = {11'd0, hi_q[25:0], seed_q[47:21]};
			CMD_BOOL:    result = {63'd0, seed_q[47]};
			CMD_FLOAT:   result = {40'd0, seed_q[47:24]};
			default:     result = '0;
		endcase
	end

	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			value_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("multiplier phase out of range");
	a_rem_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < bound_q)) else $error("remainder not below bound");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!out_valid_q || m_tready)) else $error("pending result overwritten");

endmodule

[rtl/jlcg_ctrl.sv]
// Controller FSM: sequences seed steps, remainder passes and result write per command.
// Depends on jlcg_pkg.
module jlcg_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [jlcg_pkg::CMD_W-1:0]    command,
	input  jlcg_pkg::jlcg_stat_t          status,
	output jlcg_pkg::jlcg_cmd_t           cmd
);
	import jlcg_pkg::*;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	cmd_t   cmd_in;
	logic   second_q;
	logic   draw_in;

	assign cmd_in = cmd_t'(command);

	always_comb begin
		case (cmd_in)
			CMD_INT, CMD_BOUNDED, CMD_LONG, CMD_DOUBLE, CMD_BOOL, CMD_FLOAT: draw_in = 1'b1;
			default: draw_in = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = draw_in ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: begin
				if (status.mul_last) begin
					case (cmd_q)
						CMD_BOUNDED: state_d = status.pow2 ? ST_DONE : ST_DLOAD;
						CMD_LONG, CMD_DOUBLE: state_d = second_q ? ST_DONE : ST_HI;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_HI:    state_d = ST_MUL;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = status.reject ? ST_MUL : ST_DONE;
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.reseed    = cmd.load && (cmd_in == CMD_RESEED);
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.hold_hi   = (state_q == ST_HI);
		cmd.div_start = (state_q == ST_DLOAD);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.write_out = (state_q == ST_DONE) && status.out_free;
		cmd.op        = cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= CMD_RESEED;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cmd_q    <= cmd_in;
				second_q <= 1'b0;
			end else if (cmd.hold_hi) begin
				second_q <= 1'b1;
			end
		end
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_step && cmd.div_step)) else $error("multiplier and divider both active");
	a_hi_before_second: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold_hi |=> (second_q && state_q == ST_MUL)) else $error("second draw not started");

endmodule

[rtl/java_lcg_random_generator.sv]
// Top level of the 48-bit LCG random generator (java.util.Random sequence).
// Depends on jlcg_pkg, jlcg_ctrl and jlcg_dp.
//
// Usage:
//   Slave channel (s_*) carries one command per transaction; master channel (m_*)
//   returns exactly one 64-bit value per command (zero for reseed and code 7).
//   Commands: reseed, int, bounded int, long, double numerator (/2^53), bool,
//   float numerator (/2^24).
// Timing:
//   One command at a time; s_tready is high only while the controller is idle.
//   Each seed step runs the 48x35 multiply as three 16-bit partial-product passes.
//   After the accepting edge the controller runs these steps before the result write:
//     reseed, code 7  : none;  int, bool, float, power-of-two bound : one step
//     long, double    : two steps, upper draw held between (two draws)
//     bounded int     : per attempt a step, load, 31 remainder bits, check;
//                       a rejected draw repeats the attempt.
//   s_tready returns in the cycle after the result write; the serial remainder makes
//   bounded int the slowest command.
// Reset: arst_n clears the controller, the output valid flag and the seed (zero).
// Stall: the result sits in an output register; the next command may be accepted
//   and worked on while it waits, and only the final write stalls on m_tready.
module java_lcg_random_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [2:0] command, [66:3] seed_value, [97:67] bound, [103:98] zero
	input  logic [jlcg_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] value
	output logic [jlcg_pkg::VALUE_W-1:0]    m_tdata
);
	import jlcg_pkg::*;

	jlcg_cmd_t  cmd;
	jlcg_stat_t status;

	jlcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tdata[CMD_W-1:0]),
		.status   (status),
		.cmd      (cmd)
	);

	jlcg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_value (s_tdata[CMD_W+SVAL_W-1:CMD_W]),
		.bound      (s_tdata[CMD_W+SVAL_W+BOUND_W-1:CMD_W+SVAL_W]),
		.cmd        (cmd),
		.status     (status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

[tb/jlcg_draw_checker.sv]
`timescale 1ns / 100ps
// Checker for java_lcg_random_generator: watches both stream channels, predicts each draw
// from its own copy of the 48-bit seed and compares results in order. Depends on jlcg_pkg.
module jlcg_draw_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [jlcg_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [jlcg_pkg::VALUE_W-1:0]  m_tdata,
	output int                            pending,
	output int                            errors
);
	import jlcg_pkg::*;

	localparam int SHOWN = 10;

	logic [SEED_W-1:0]  lcg_state;
	logic [VALUE_W-1:0] expected_draws [$];
	int                 mismatch_count;

	// Advance the seed, return its top nbits as a sign-extended 32-bit draw.
	function automatic logic [VALUE_W-1:0] step_bits(input int nbits);
		logic [31:0] raw;
		lcg_state = lcg_state * SEED_W'(LCG_MULT) + LCG_ADD;
		raw = 32'(lcg_state >> (SEED_W - nbits));
		return {{32{raw[31]}}, raw};
	endfunction

	function automatic logic [VALUE_W-1:0] predict_draw(input logic [CMD_W-1:0] op,
			input logic [SVAL_W-1:0] sv, input logic [BOUND_W-1:0] bnd);
		logic [31:0]        b;
		logic [31:0]        r;
		logic [31:0]        v;
		logic [VALUE_W-1:0] hi;
		logic [VALUE_W-1:0] lo;
		b = {1'b0, bnd};
		case (op)
			CMD_RESEED: begin
				lcg_state = sv[SEED_W-1:0] ^ SEED_W'(LCG_MULT);
				return '0;
			end
			CMD_INT: begin
				return step_bits(32);
			end
			CMD_BOUNDED: begin
				// zero bound also takes the power-of-two path
				if ((b & (~b + 32'd1)) == b) begin
					hi = step_bits(31);
					r = hi[31:0];
					return (64'(b) * 64'(r)) >> 31;
				end
				hi = step_bits(31);
				r = hi[31:0];
				v = r % b;
				while (((r - v + b - 32'd1) & 32'h8000_0000) != 32'd0) begin
					hi = step_bits(31);
					r = hi[31:0];
					v = r % b;
				end
				return {32'd0, v};
			end
			CMD_LONG: begin
				hi = step_bits(32);
				lo = step_bits(32);
				return (hi << 32) + lo;
			end
			CMD_DOUBLE: begin
				hi = step_bits(26);
				lo = step_bits(27);
				return (hi << 27) + lo;
			end
			CMD_BOOL: begin
				return step_bits(1);
			end
			CMD_FLOAT: begin
				return step_bits(24);
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : draw_watch
		logic [VALUE_W-1:0] want;
		if (!arst_n) begin
			lcg_state = '0;
			expected_draws.delete();
			mismatch_count = 0;
			pending <= 0;
			errors <= 0;
		end else begin
			// compare first: a result never belongs to a command taken at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_draws.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOWN)
						$display("unexpected result value=%h", m_tdata);
				end else begin
					want = expected_draws.pop_front();
					if (m_tdata !== want) begin
						mismatch_count++;
						if (mismatch_count <= SHOWN)
							$display("value mismatch: expected %h actual %h", want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_draws.push_back(predict_draw(s_tdata[CMD_W-1:0],
					s_tdata[CMD_W +: SVAL_W], s_tdata[CMD_W+SVAL_W +: BOUND_W]));
			pending <= expected_draws.size();
			errors <= mismatch_count;
		end
	end

endmodule

[tb/java_lcg_random_generator_test.sv]
`timescale 1ns / 100ps
// Testbench top for java_lcg_random_generator: makes command stimulus, paces results and
// gives the verdict. Depends on jlcg_pkg, the block and jlcg_draw_checker.
module java_lcg_random_generator_test;
	import jlcg_pkg::*;

	// code seven is outside the command enum; the block must answer zero and keep the seed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int HOLD_AT      = 300;  // issued count that triggers the long result stall
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 80;   // > one bounded attempt plus output write

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// [2:0] command, [66:3] seed_value, [97:67] bound, [103:98] zero
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// [63:0] value
	logic [VALUE_W-1:0]  m_tdata;

	int pending;
	int errors;
	int issued = 0;      // accepted command transactions
	int burst_left = 0;  // remaining back-to-back commands in a no-gap stretch
	int cycle_count = 0;

	always #10 clk = ~clk;

	java_lcg_random_generator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	jlcg_draw_checker draw_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.pending  (pending),
		.errors   (errors)
	);

	// Offer one command and hold it until the block takes it. Afterwards either leave
	// tvalid high for the next call (no gap) or drop it for a random idle stretch.
	// Entered and left on a rising edge.
	task automatic issue_command(input logic [CMD_W-1:0] op, input logic [SVAL_W-1:0] sv,
			input logic [BOUND_W-1:0] bnd);
		int gap;
		int roll;
		s_tdata <= {{(S_DATA_W-CMD_W-SVAL_W-BOUND_W){1'b0}}, bnd, sv, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		issued++;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				burst_left = $urandom_range(20, 80);
			if (roll < 50)
				gap = 0;
			else if (roll < 90)
				gap = $urandom_range(1, 3);
			else if (roll < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(30, 90);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and let every outstanding draw come back before going on.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Global watchdog: any hang ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("java_lcg_random_generator regression: fail");
			$finish;
		end
	end

	// Result side: random tready with short and long stalls, stretches of always-ready,
	// and one long hold-off once enough commands went in so the block backs up.
	initial begin : result_pacing
		int   roll;
		int   len;
		logic rdy;
		logic long_hold_done;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && issued >= HOLD_AT) begin
				long_hold_done = 1'b1;
				rdy = 1'b0;
				len = HOLD_CYCLES;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					rdy = 1'b1;
					len = $urandom_range(100, 400);
				end else if (roll < 55) begin
					rdy = 1'b1;
					len = $urandom_range(1, 6);
				end else if (roll < 93) begin
					rdy = 1'b0;
					len = $urandom_range(1, 4);
				end else begin
					rdy = 1'b0;
					len = $urandom_range(20, 90);
				end
			end
			m_tready <= rdy;
			repeat (len) @(posedge clk);
		end
	end

	initial begin : command_stimulus
		int                  roll;
		logic [CMD_W-1:0]    op;
		logic [SVAL_W-1:0]   sv;
		logic [BOUND_W-1:0]  bnd;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first draw runs from the all-zero reset seed.
		issue_command(CMD_INT,     64'h0123_4567_89AB_CDEF, 31'd5);
		issue_command(CMD_RESEED,  64'h0000_0000_0000_0000, 31'd0);
		issue_command(CMD_INT,     64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
		issue_command(CMD_RESEED,  64'h8000_0000_0000_0000, 31'd0);
		issue_command(CMD_LONG,    64'h0,                   31'd0);
		issue_command(CMD_RESEED,  64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
		issue_command(CMD_DOUBLE,  64'h0,                   31'd0);
		issue_command(CMD_BOOL,    64'h0,                   31'd0);
		issue_command(CMD_FLOAT,   64'h0,                   31'd0);
		// bounded: power-of-two extremes, zero bound, max bound and heavy-rejection bounds
		issue_command(CMD_BOUNDED, 64'h0,                   31'd1);
		issue_command(CMD_BOUNDED, 64'h0,                   31'd0);
		issue_command(CMD_BOUNDED, 64'h0,                   31'h4000_0000);
		issue_command(CMD_BOUNDED, 64'h0,                   31'h7FFF_FFFF);
		issue_command(CMD_BOUNDED, 64'h0,                   31'd3);
		issue_command(CMD_BOUNDED, 64'h0,                   31'h4000_0001);
		issue_command(CMD_BOUNDED, 64'h0,                   31'h5555_5555);
		// unused code: zero result, seed untouched (next int shows it)
		issue_command(CMD_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
		issue_command(CMD_INT,     64'h0,                   31'd0);
		issue_command(CMD_RESEED,  64'hFFFF_FFFF_FFFF_FFFF, 31'd0);
		issue_command(CMD_LONG,    64'h0,                   31'd0);
		issue_command(CMD_BOOL,    64'h0,                   31'd0);
		issue_command(CMD_FLOAT,   64'h0,                   31'd0);
		issue_command(CMD_DOUBLE,  64'h0,                   31'd0);
		wait_drained();

		// Random part: mostly draws with occasional reseeds; bounds mix power-of-two,
		// small, full-range and near the rejection-heavy region.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < 10)
				op = CMD_RESEED;
			else if (roll < 40)
				op = CMD_BOUNDED;
			else if (roll < 50)
				op = CMD_INT;
			else if (roll < 60)
				op = CMD_LONG;
			else if (roll < 70)
				op = CMD_DOUBLE;
			else if (roll < 82)
				op = CMD_BOOL;
			else if (roll < 97)
				op = CMD_FLOAT;
			else
				op = CMD_UNUSED;
			sv = {$urandom, $urandom};
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					bnd = 31'd1 << $urandom_range(0, 30);
				end
				3, 4: begin
					bnd = 31'($urandom_range(1, 1000));
				end
				5, 6: begin
					bnd = 31'($urandom);
				end
				7: begin
					bnd = 31'h4000_0000 + 31'($urandom_range(1, 4096));
				end
				8: begin
					bnd = 31'h7FFF_FFFF - 31'($urandom_range(0, 4096));
				end
				default: begin
					bnd = 31'($urandom_range(0, 2));
				end
			endcase
			issue_command(op, sv, bnd);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("java_lcg_random_generator regression: pass");
		else
			$display("java_lcg_random_generator regression: fail");
		$finish;
	end

endmodule

[java_lcg_random_generator.f]
rtl/jlcg_pkg.sv
rtl/jlcg_dp.sv
rtl/jlcg_ctrl.sv
rtl/java_lcg_random_generator.sv
tb/jlcg_draw_checker.sv
tb/java_lcg_random_generator_test.sv
